### src/mhx_pkg.sv
`default_nettype none

package mhx_pkg;

    localparam logic [63:0] P1 = 64'h6a09e667f3bcc909;
    localparam logic [63:0] P2 = 64'h3c6ef372fe94f82c;
    localparam logic [63:0] P3 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] MX = 64'hff51afd7ed558ccd;
    localparam logic [63:0] X1 = 64'h736f6d6570736575;
    localparam logic [63:0] X2 = 64'h6c7967656e657261;
    localparam logic [63:0] X3 = 64'h25232284e49cf2cb;
    localparam int          SHIFT = 13;

    // configuration register indexes
    localparam int              CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP = 1'b1;

    // microcode
    localparam int              PC_W    = 5;
    localparam logic [PC_W-1:0] PC_FIN  = 5'd10;
    localparam logic [PC_W-1:0] PC_LAST = 5'd23;

    localparam int              OP_W       = 3;
    localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
    localparam logic [OP_W-1:0] OP_LD_ABS1 = 3'd1;
    localparam logic [OP_W-1:0] OP_LD_ABS2 = 3'd2;
    localparam logic [OP_W-1:0] OP_WB_ABS  = 3'd3;
    localparam logic [OP_W-1:0] OP_LD_FIN  = 3'd4;
    localparam logic [OP_W-1:0] OP_MIX1    = 3'd5;
    localparam logic [OP_W-1:0] OP_MIX2    = 3'd6;
    localparam logic [OP_W-1:0] OP_EMIT    = 3'd7;

    localparam int               JMP_W     = 2;
    localparam logic [JMP_W-1:0] J_NEXT    = 2'd0;
    localparam logic [JMP_W-1:0] J_NOABS   = 2'd1;
    localparam logic [JMP_W-1:0] J_NOTLAST = 2'd2;
    localparam logic [JMP_W-1:0] J_END     = 2'd3;

    typedef struct packed {
        logic en;
        logic clr;
        logic a_hi;
        logic b_hi;
    } t_mul_ctl;

    typedef struct packed {
        t_mul_ctl          mul;
        logic [OP_W-1:0]   op;
        logic [JMP_W-1:0]  jmp;
        logic [PC_W-1:0]   tgt;
    } t_uop;

    function automatic logic [63:0] bswap64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic t_uop mul_step(input logic clr, input logic a_hi, input logic b_hi);
        t_uop u;
        u.mul.en   = 1'b1;
        u.mul.clr  = clr;
        u.mul.a_hi = a_hi;
        u.mul.b_hi = b_hi;
        u.op       = OP_NOP;
        u.jmp      = J_NEXT;
        u.tgt      = '0;
        return u;
    endfunction

    function automatic t_uop ctl_step(input logic [OP_W-1:0] op, input logic [JMP_W-1:0] jmp,
                                      input logic [PC_W-1:0] tgt);
        t_uop u;
        u.mul = '0;
        u.op  = op;
        u.jmp = jmp;
        u.tgt = tgt;
        return u;
    endfunction

    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // absorb: (acc ^ chunk) * p1, low half only
            5'd0:  u = ctl_step(OP_LD_ABS1, J_NOABS, PC_FIN);
            5'd1:  u = mul_step(1'b1, 1'b0, 1'b0);
            5'd2:  u = mul_step(1'b0, 1'b0, 1'b1);
            5'd3:  u = mul_step(1'b0, 1'b1, 1'b0);
            // prev * round_key, full product
            5'd4:  u = ctl_step(OP_LD_ABS2, J_NEXT, '0);
            5'd5:  u = mul_step(1'b1, 1'b0, 1'b0);
            5'd6:  u = mul_step(1'b0, 1'b0, 1'b1);
            5'd7:  u = mul_step(1'b0, 1'b1, 1'b0);
            5'd8:  u = mul_step(1'b0, 1'b1, 1'b1);
            5'd9:  u = ctl_step(OP_WB_ABS, J_NOTLAST, '0);
            // finalization: mulhi with keyed constant, then multiplies by p3 and mx, then emit
            5'd10: u = ctl_step(OP_LD_FIN, J_NEXT, '0);
            5'd11: u = mul_step(1'b1, 1'b0, 1'b0);
            5'd12: u = mul_step(1'b0, 1'b0, 1'b1);
            5'd13: u = mul_step(1'b0, 1'b1, 1'b0);
            5'd14: u = mul_step(1'b0, 1'b1, 1'b1);
            5'd15: u = ctl_step(OP_MIX1, J_NEXT, '0);
            5'd16: u = mul_step(1'b1, 1'b0, 1'b0);
            5'd17: u = mul_step(1'b0, 1'b0, 1'b1);
            5'd18: u = mul_step(1'b0, 1'b1, 1'b0);
            5'd19: u = ctl_step(OP_MIX2, J_NEXT, '0);
            5'd20: u = mul_step(1'b1, 1'b0, 1'b0);
            5'd21: u = mul_step(1'b0, 1'b0, 1'b1);
            5'd22: u = mul_step(1'b0, 1'b1, 1'b0);
            5'd23: u = ctl_step(OP_EMIT, J_END, '0);
            default: u = ctl_step(OP_NOP, J_END, '0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### src/mulhi_xor_hash64_engine.sv
// one item at a time: the input stalls while the sequencer runs an item, and the emit step
// also waits while the output word is stalled; products come from one shared 32x32 multiplier,
// 3 or 4 passes per product
// reset: synchronous active low, clears sequencer, message flag, output valid and config registers
`default_nettype none

module mulhi_xor_hash64_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [63:0] o_digest,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [mhx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    logic [63:0]              r_seed, n_seed;
    logic                     r_swap, n_swap;
    logic                     r_busy, n_busy;
    logic [mhx_pkg::PC_W-1:0] r_pc, n_pc;
    logic                     r_in_msg, n_in_msg;
    logic                     r_out_valid, n_out_valid;
    logic [63:0]              r_digest, n_digest;
    logic [63:0]              r_acc, n_acc;
    logic [63:0]              r_rk, n_rk;
    logic [63:0]              r_chunk, n_chunk;
    logic                     r_do_abs, n_do_abs;
    logic                     r_adv, n_adv;
    logic                     r_last, n_last;
    logic [63:0]              r_prev, n_prev;
    logic [63:0]              r_ma, n_ma;
    logic [63:0]              r_mb, n_mb;

    mhx_pkg::t_uop     uop;
    mhx_pkg::t_mul_ctl mul_ctl;
    logic [127:0]      prod;
    logic [63:0]       hi, lo;
    logic              in_acc;
    logic              emit_go;
    logic              seq_hold;
    logic [63:0]       mask;
    logic [63:0]       full_word;
    logic [63:0]       tail_chunk;
    logic              is_full;
    logic              is_tail;
    logic [63:0]       hb;
    logic [63:0]       fin;

    mhx_mul u_mul (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_prod (prod)
    );

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_digest    = r_digest;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        uop        = mhx_pkg::ucode(r_pc);
        mul_ctl    = uop.mul;
        mul_ctl.en = uop.mul.en && r_busy;
        hi         = prod[127:64];
        lo         = prod[63:0];
        in_acc     = i_in_valid && !r_busy;
        emit_go    = r_busy && (uop.op == mhx_pkg::OP_EMIT) && (!r_out_valid || !i_out_stall);
        seq_hold   = r_busy && (uop.op == mhx_pkg::OP_EMIT) && !emit_go;

        for (int b = 0; b < 8; b++) begin
            mask[8*b +: 8] = (i_byte_count > 4'(b)) ? 8'hff : 8'h00;
        end
        full_word  = r_swap ? mhx_pkg::bswap64(i_word) : i_word;
        tail_chunk = {4'd0, i_byte_count, 56'd0} | (i_word & mask);
        is_full    = !i_last || i_byte_count[3];
        is_tail    = i_last && !i_byte_count[3] && (i_byte_count != 4'd0);

        // finalization tail: byte swap, shift-xor, xor with kept value
        hb  = mhx_pkg::bswap64(lo);
        fin = hb ^ (hb >> mhx_pkg::SHIFT) ^ r_prev;

        n_seed      = r_seed;
        n_swap      = r_swap;
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_in_msg    = r_in_msg;
        n_out_valid = r_out_valid;
        n_digest    = r_digest;
        n_acc       = r_acc;
        n_rk        = r_rk;
        n_chunk     = r_chunk;
        n_do_abs    = r_do_abs;
        n_adv       = r_adv;
        n_last      = r_last;
        n_prev      = r_prev;
        n_ma        = r_ma;
        n_mb        = r_mb;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                mhx_pkg::CFG_SEED: n_seed = i_cfg_data;
                mhx_pkg::CFG_SWAP: n_swap = i_cfg_data[0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (in_acc) begin
            n_busy   = 1'b1;
            n_pc     = '0;
            n_chunk  = is_full ? full_word : tail_chunk;
            n_do_abs = is_full || is_tail;
            n_adv    = is_full;
            n_last   = i_last;
            if (!r_in_msg) begin
                n_acc    = mhx_pkg::bswap64(r_seed ^ mhx_pkg::X1) | 64'd1;
                n_rk     = ((r_seed ^ mhx_pkg::X2) | 64'd1) + mhx_pkg::P2;
                n_in_msg = 1'b1;
            end
        end

        if (r_busy) begin
            case (uop.op)
                mhx_pkg::OP_LD_ABS1: begin
                    n_ma   = r_acc ^ r_chunk;
                    n_mb   = mhx_pkg::P1;
                    n_prev = r_acc;
                end
                mhx_pkg::OP_LD_ABS2: begin
                    n_prev = lo;
                    n_ma   = r_prev;
                    n_mb   = r_rk;
                end
                mhx_pkg::OP_WB_ABS: begin
                    n_acc = r_prev ^ hi;
                    if (r_adv) begin
                        n_rk = r_rk + mhx_pkg::P2;
                    end
                end
                mhx_pkg::OP_LD_FIN: begin
                    n_ma = r_acc;
                    n_mb = (r_seed ^ mhx_pkg::X3) | 64'd1;
                end
                mhx_pkg::OP_MIX1: begin
                    n_ma = r_acc ^ hi;
                    n_mb = mhx_pkg::P3;
                end
                mhx_pkg::OP_MIX2: begin
                    n_prev = lo;
                    n_ma   = lo;
                    n_mb   = mhx_pkg::MX;
                end
                mhx_pkg::OP_EMIT: begin
                    if (emit_go) begin
                        n_digest    = fin;
                        n_out_valid = 1'b1;
                        n_in_msg    = 1'b0;
                    end
                end
                default: ;
            endcase

            case (uop.jmp)
                mhx_pkg::J_NEXT: n_pc = r_pc + mhx_pkg::PC_W'(1);
                mhx_pkg::J_NOABS: begin
                    n_pc = r_do_abs ? r_pc + mhx_pkg::PC_W'(1) : uop.tgt;
                end
                mhx_pkg::J_NOTLAST: begin
                    if (r_last) begin
                        n_pc = r_pc + mhx_pkg::PC_W'(1);
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                mhx_pkg::J_END: begin
                    if (emit_go) begin
                        n_busy = 1'b0;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_swap      <= 1'b0;
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seed      <= n_seed;
            r_swap      <= n_swap;
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_in_msg    <= n_in_msg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digest <= n_digest;
        r_acc    <= n_acc;
        r_rk     <= n_rk;
        r_chunk  <= n_chunk;
        r_do_abs <= n_do_abs;
        r_adv    <= n_adv;
        r_last   <= n_last;
        r_prev   <= n_prev;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
    end

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy && (r_pc == '0))
        else $error("sequencer did not start at step zero");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_busy && (uop.op == mhx_pkg::OP_EMIT)))
        else $error("digest shown outside the emit step");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= mhx_pkg::PC_LAST))
        else $error("step counter ran past the program");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_hold |=> $stable(r_pc) && r_busy)
        else $error("sequencer moved while output word was stalled");

endmodule

`default_nettype wire

### src/mhx_mul.sv
`default_nettype none

module mhx_mul (
    input  wire logic              i_clk,
    input  wire mhx_pkg::t_mul_ctl i_ctl,
    input  wire logic [63:0]       i_a,
    input  wire logic [63:0]       i_b,
    output logic      [127:0]      o_prod
);

    logic [127:0] r_prod;
    logic [127:0] n_prod;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] base;

    always_comb begin
        a_half = i_ctl.a_hi ? i_a[63:32] : i_a[31:0];
        b_half = i_ctl.b_hi ? i_b[63:32] : i_b[31:0];
        pp     = 64'(a_half) * 64'(b_half);
        case ({i_ctl.a_hi, i_ctl.b_hi})
            2'b00:   pp_sh = {64'd0, pp};
            2'b01:   pp_sh = {32'd0, pp, 32'd0};
            2'b10:   pp_sh = {32'd0, pp, 32'd0};
            2'b11:   pp_sh = {pp, 64'd0};
            default: pp_sh = '0;
        endcase
        base   = i_ctl.clr ? 128'd0 : r_prod;
        n_prod = base + pp_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### test/mulhi_xor_hash64_engine_tb.sv
`timescale 1ns / 100ps

module mulhi_xor_hash64_engine_tb;

    localparam logic [63:0] K_P1 = 64'h6a09e667f3bcc909;
    localparam logic [63:0] K_P2 = 64'h3c6ef372fe94f82c;
    localparam logic [63:0] K_P3 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] K_MX = 64'hff51afd7ed558ccd;
    localparam logic [63:0] K_X1 = 64'h736f6d6570736575;
    localparam logic [63:0] K_X2 = 64'h6c7967656e657261;
    localparam logic [63:0] K_X3 = 64'h25232284e49cf2cb;
    localparam int          XS_SHIFT     = 13;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          MAX_PRINTS   = 20;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_word       = '0;
    logic [3:0]  i_byte_count = '0;
    logic        i_last       = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [63:0] o_digest;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [mhx_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data   = '0;

    // predictor state, reset values
    logic [63:0] key_seed = '0;
    logic        swap_en  = 1'b0;
    logic [63:0] acc      = '0;
    logic [63:0] rkey     = '0;
    logic        in_msg   = 1'b0;

    logic [63:0] pending_digests[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_left     = 0;
    int n_errors      = 0;
    int n_sent        = 0;
    int n_digests     = 0;
    int n_cfg_writes  = 0;

    mulhi_xor_hash64_engine u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_word       (i_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digest     (o_digest),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] byte_rev(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r = {r[55:0], v[8*i +: 8]};
        end
        return r;
    endfunction

    function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    function automatic logic [63:0] finish_digest(input logic [63:0] a);
        logic [63:0] h;
        logic [63:0] keep;
        h = a ^ mul_hi(a, (key_seed ^ K_X3) | 64'd1);
        h = h * K_P3;
        keep = h;
        h = byte_rev(h * K_MX);
        h = h ^ (h >> XS_SHIFT) ^ keep;
        return h;
    endfunction

    function automatic logic [63:0] rand_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return '0;
        end
        if (pick < 8) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    task automatic absorb_chunk(input logic [63:0] chunk);
        logic [63:0] prev;
        prev = acc;
        acc = (acc ^ chunk) * K_P1;
        acc = acc ^ mul_hi(prev, rkey);
    endtask

    task automatic hash_item(input logic [63:0] w, input logic [3:0] cnt, input logic lst);
        logic [63:0] mask;
        if (!in_msg) begin
            acc = byte_rev(key_seed ^ K_X1) | 64'd1;
            rkey = ((key_seed ^ K_X2) | 64'd1) + K_P2;
            in_msg = 1'b1;
        end
        if (!lst || cnt >= 4'd8) begin
            absorb_chunk(swap_en ? byte_rev(w) : w);
            rkey = rkey + K_P2;
        end else if (cnt != 4'd0) begin
            // tail bytes stay little-endian, count in the top byte
            mask = (64'd1 << (8 * cnt)) - 64'd1;
            absorb_chunk((64'(cnt) << 56) | (w & mask));
        end
        if (lst) begin
            pending_digests.push_back(finish_digest(acc));
            in_msg = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            hash_item(i_word, i_byte_count, i_last);
        end
    end

    always @(posedge i_clk) begin : digest_check
        logic [63:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_digests.size() == 0) begin
                report_mismatch("digest word with none pending", o_digest, '0);
            end else begin
                want = pending_digests.pop_front();
                n_digests++;
                if (o_digest !== want) begin
                    report_mismatch("digest mismatch", o_digest, want);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_word <= w;
        i_byte_count <= cnt;
        i_last <= lst;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        n_sent++;
    endtask

    task automatic send_message(input int n_full);
        logic [3:0] cnt;
        for (int k = 0; k < n_full; k++) begin
            send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        end
        if ($urandom_range(0, 99) < 80) begin
            cnt = 4'($urandom_range(0, 8));
        end else begin
            cnt = 4'($urandom_range(9, 15));
        end
        send_word(rand_word(), cnt, 1'b1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_digests.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mhx_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            mhx_pkg::CFG_SEED: key_seed = val;
            mhx_pkg::CFG_SWAP: swap_en = val[0];
            default: ;
        endcase
        n_cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_single_word_messages();
        src_idle_pct = 20;
        sink_idle_pct = 30;
        // empty message
        send_word('1, 4'd0, 1'b1);
        for (int c = 1; c <= 8; c++) begin
            send_word('1, 4'(c), 1'b1);
        end
        // oversized count on a last word saturates to a full word
        send_word('0, 4'd15, 1'b1);
        // non-last words ignore the count
        send_word('1, 4'd0, 1'b0);
        send_word('0, 4'd15, 1'b0);
        send_word(64'h0123456789abcdef, 4'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_keyed_swapped();
        write_reg(mhx_pkg::CFG_SEED, '1);
        write_reg(mhx_pkg::CFG_SWAP, 64'd1);
        send_word(64'h0807060504030201, 4'd8, 1'b0);
        send_word(64'hfedcba9876543210, 4'd8, 1'b1);
        send_word(64'hffffffffffa1b2c3, 4'd3, 1'b1);
        wait_drained();
    endtask

    task automatic test_rekey_mid_message();
        write_reg(mhx_pkg::CFG_SEED, 64'h0123456789abcdef);
        write_reg(mhx_pkg::CFG_SWAP, 64'd0);
        send_word(rand_word(), 4'd8, 1'b0);
        send_word(rand_word(), 4'd8, 1'b0);
        wait_drained();
        write_reg(mhx_pkg::CFG_SEED, {$urandom, $urandom});
        write_reg(mhx_pkg::CFG_SWAP, 64'd1);
        send_word(rand_word(), 4'd8, 1'b0);
        send_word(rand_word(), 4'd5, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_left <= 300;
        repeat (8) send_message($urandom_range(0, 2));
        wait_drained();
    endtask

    task automatic test_random_messages(input int src_pct, input int sink_pct, input int n_items);
        int base;
        int msgs;
        int pick;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        base = n_sent;
        msgs = 0;
        while (n_sent - base < n_items) begin
            if ($urandom_range(0, 99) < 90) begin
                send_message($urandom_range(0, 6));
            end else begin
                send_message($urandom_range(7, 24));
            end
            msgs++;
            if (msgs % 40 == 0) begin
                wait_drained();
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    write_reg(mhx_pkg::CFG_SEED, '0);
                end else if (pick < 4) begin
                    write_reg(mhx_pkg::CFG_SEED, '1);
                end else begin
                    write_reg(mhx_pkg::CFG_SEED, {$urandom, $urandom});
                end
                write_reg(mhx_pkg::CFG_SWAP, 64'($urandom_range(0, 1)));
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_word_messages();
        test_keyed_swapped();
        test_rekey_mid_message();
        test_output_backpressure();
        test_random_messages(13, 74, 660);
        test_random_messages(74, 13, 660);
        test_random_messages(0, 0, 680);
        $display("%0d words hashed, %0d digests compared, %0d register writes",
                 n_sent, n_digests, n_cfg_writes);
        $display("tails of every length, swapped and plain words, rekey mid-message, hold-off");
        if (n_errors == 0) begin
            $display("mulhi_xor_hash64_engine_tb OK");
        end else begin
            $display("mulhi_xor_hash64_engine_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d digests pending", pending_digests.size());
        $display("mulhi_xor_hash64_engine_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
src/mhx_pkg.sv
src/mhx_mul.sv
src/mulhi_xor_hash64_engine.sv
test/mulhi_xor_hash64_engine_tb.sv
